[rtl/mch_pkg.sv]
// types, codes and constants shared by the convex hull core
package mch_pkg;

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               final_point;
   } req_type;

   typedef struct packed {
      logic signed [15:0] hx;
      logic signed [15:0] hy;
      logic               end_of_hull;
      logic [1:0]         status;
   } rsp_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FEW  = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_INS_RD,
      OP_INS_CMP,
      OP_INS_PUT,
      OP_HULL,
      OP_SM_RD,
      OP_SM_OUT,
      OP_INIT0,
      OP_INIT1,
      OP_INIT2,
      OP_PUSH_RD,
      OP_PUSH_WR,
      OP_CR_MUL,
      OP_CR_EVAL,
      OP_POP_S,
      OP_POP_P,
      OP_NEXT,
      OP_EM_INIT,
      OP_EM_S,
      OP_EM_P,
      OP_EM_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic pos_zero;
      logic pos_one;
      logic shift;
      logic fin;
      logic small_set;
      logic more_push;
      logic right;
      logic pop_more;
      logic last_push;
      logic lower;
      logic em_last;
   } stat_type;

endpackage

[rtl/mch_ctrl.sv]
// sequencer for insertion, chain building and hull emission
module mch_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output mch_pkg::cmd_type  cmd,
   input  mch_pkg::stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_AFTER, S_HULL, S_SM_RD, S_SM_OUT,
      S_INIT0, S_INIT1, S_INIT2, S_PUSH_RD, S_PUSH_WR, S_CR_MUL, S_CR_EVAL,
      S_POP_S, S_POP_P, S_NEXT, S_EM_INIT, S_EM_S, S_EM_P, S_EM_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = mch_pkg::OP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = mch_pkg::OP_LOAD;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            cmd.op = mch_pkg::OP_INS_RD;
            if (stat.full || stat.pos_zero) state_in = S_AFTER;
            else state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            cmd.op = mch_pkg::OP_INS_CMP;
            if (!stat.shift) state_in = S_AFTER;
            else if (stat.pos_one) state_in = S_INS_PUT;
         end
         S_INS_PUT: begin
            cmd.op   = mch_pkg::OP_INS_PUT;
            state_in = S_AFTER;
         end
         S_AFTER: state_in = stat.fin ? S_HULL : S_IDLE;
         S_HULL: begin
            cmd.op   = mch_pkg::OP_HULL;
            state_in = stat.small_set ? S_SM_RD : S_INIT0;
         end
         S_SM_RD: begin
            cmd.op   = mch_pkg::OP_SM_RD;
            state_in = S_SM_OUT;
         end
         S_SM_OUT: begin
            cmd.op   = mch_pkg::OP_SM_OUT;
            state_in = S_IDLE;
         end
         S_INIT0: begin
            cmd.op   = mch_pkg::OP_INIT0;
            state_in = S_INIT1;
         end
         S_INIT1: begin
            cmd.op   = mch_pkg::OP_INIT1;
            state_in = S_INIT2;
         end
         S_INIT2: begin
            cmd.op   = mch_pkg::OP_INIT2;
            state_in = stat.more_push ? S_PUSH_RD : S_NEXT;
         end
         S_PUSH_RD: begin
            cmd.op   = mch_pkg::OP_PUSH_RD;
            state_in = S_PUSH_WR;
         end
         S_PUSH_WR: begin
            cmd.op   = mch_pkg::OP_PUSH_WR;
            state_in = S_CR_MUL;
         end
         S_CR_MUL: begin
            cmd.op   = mch_pkg::OP_CR_MUL;
            state_in = S_CR_EVAL;
         end
         S_CR_EVAL: begin
            cmd.op = mch_pkg::OP_CR_EVAL;
            if (stat.right || !stat.pop_more) state_in = S_NEXT;
            else state_in = S_POP_S;
         end
         S_POP_S: begin
            cmd.op   = mch_pkg::OP_POP_S;
            state_in = S_POP_P;
         end
         S_POP_P: begin
            cmd.op   = mch_pkg::OP_POP_P;
            state_in = S_CR_MUL;
         end
         S_NEXT: begin
            cmd.op = mch_pkg::OP_NEXT;
            if (!stat.last_push) state_in = S_PUSH_RD;
            else if (stat.lower) state_in = S_EM_INIT;
            else state_in = S_INIT0;
         end
         S_EM_INIT: begin
            cmd.op   = mch_pkg::OP_EM_INIT;
            state_in = S_EM_S;
         end
         S_EM_S: begin
            cmd.op   = mch_pkg::OP_EM_S;
            state_in = S_EM_P;
         end
         S_EM_P: begin
            cmd.op   = mch_pkg::OP_EM_P;
            state_in = S_EM_OUT;
         end
         S_EM_OUT: begin
            cmd.op   = mch_pkg::OP_EM_OUT;
            state_in = stat.em_last ? S_IDLE : S_EM_S;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mch_pkg::OP_LOAD) |-> (state_ff == S_IDLE))
      else $error("load issued outside idle");
   a_emit_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EM_OUT) |-> ($past(state_ff) == S_EM_P))
      else $error("emit without point read");
   a_mul_before_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CR_EVAL) |-> ($past(state_ff) == S_CR_MUL))
      else $error("cross evaluated without products");
`endif

endmodule

[rtl/mch_dp.sv]
// point store, chain stack, cross product unit and result register
module mch_dp #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  mch_pkg::req_type  req_data,
   input  mch_pkg::cmd_type  cmd,
   output mch_pkg::stat_type stat,
   output logic              rsp_strobe,
   output mch_pkg::rsp_type  rsp_data
);

   localparam int CB  = COORD_BITS;
   localparam int IW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int DW  = $clog2(2 * MAX_POINTS + 1);
   localparam int SW  = $clog2(2 * MAX_POINTS);
   localparam int PW  = 2 * CB + 2;
   localparam int CRW = PW + 1;

   logic [2*CB-1:0] pmem [MAX_POINTS];
   logic [IW-1:0]   smem [2*MAX_POINTS];

   logic [2*CB-1:0] p_rdata_ff;
   logic [IW-1:0]   s_rdata_ff;

   logic [CW-1:0] cnt_ff;
   logic          ovf_ff, fin_ff, lower_ff;
   logic [IW-1:0] pos_ff, j_ff;
   logic [DW-1:0] depth_ff, base_ff, upper_ff, k_ff, total_ff;
   logic [1:0]    st_ff;
   logic [IW-1:0] t1i_ff, t2i_ff, t3i_ff;
   logic signed [CB-1:0] px_ff, py_ff;
   logic signed [CB-1:0] t1x_ff, t1y_ff, t2x_ff, t2y_ff, t3x_ff, t3y_ff;
   logic signed [PW-1:0] prod1_ff, prod2_ff;
   logic          rsp_strobe_ff;
   mch_pkg::rsp_type rsp_ff;

   logic            p_we, s_we;
   logic [IW-1:0]   p_raddr, p_waddr, s_wdata;
   logic [2*CB-1:0] p_wdata;
   logic [SW-1:0]   s_raddr, s_waddr;

   logic signed [CB-1:0] rx, ry;
   logic [31:0]          in_x32, in_y32;
   logic signed [CB:0]   d1, d2, d3, d4;
   logic signed [CRW-1:0] cr;
   logic [IW-1:0]        n_m1, n_m2, pt_a, pt_b;
   logic [DW-1:0]        span;
   logic signed [31:0]   ox, oy;

   assign rx = p_rdata_ff[2*CB-1:CB];
   assign ry = p_rdata_ff[CB-1:0];
   assign in_x32 = {16'b0, req_data.px};
   assign in_y32 = {16'b0, req_data.py};
   assign n_m1 = IW'(cnt_ff - CW'(1));
   assign n_m2 = IW'(cnt_ff - CW'(2));
   assign pt_a = lower_ff ? n_m1 : IW'(0);
   assign pt_b = lower_ff ? n_m2 : IW'(1);
   assign span = depth_ff - base_ff;

   // cross product of (t3 -> t2) and (t3 -> t1)
   assign d1 = (CB+1)'(t2x_ff) - (CB+1)'(t3x_ff);
   assign d2 = (CB+1)'(t1y_ff) - (CB+1)'(t3y_ff);
   assign d3 = (CB+1)'(t1x_ff) - (CB+1)'(t3x_ff);
   assign d4 = (CB+1)'(t2y_ff) - (CB+1)'(t3y_ff);
   assign cr = CRW'(prod1_ff) - CRW'(prod2_ff);

   always_comb begin
      stat.full      = (cnt_ff == CW'(MAX_POINTS));
      stat.pos_zero  = (pos_ff == '0);
      stat.pos_one   = (pos_ff == IW'(1));
      stat.shift     = (rx > px_ff) || ((rx == px_ff) && (ry > py_ff));
      stat.fin       = fin_ff;
      stat.small_set = (cnt_ff < CW'(2));
      stat.more_push = (cnt_ff > CW'(2));
      stat.right     = cr[CRW-1];
      stat.pop_more  = (span > DW'(3));
      stat.last_push = lower_ff ? ((j_ff == '0) || (cnt_ff <= CW'(2)))
                                : (CW'(j_ff) >= (cnt_ff - CW'(1)));
      stat.lower     = lower_ff;
      stat.em_last   = ((k_ff + DW'(1)) == total_ff);
   end

   // memory address and write selection
   always_comb begin
      p_raddr = '0;
      p_we    = 1'b0;
      p_waddr = pos_ff;
      p_wdata = {px_ff, py_ff};
      s_raddr = SW'(depth_ff - DW'(4));
      s_we    = 1'b0;
      s_waddr = SW'(depth_ff);
      s_wdata = j_ff;
      case (cmd.op)
         mch_pkg::OP_INS_RD: begin
            p_raddr = pos_ff - IW'(1);
            p_we    = !stat.full && stat.pos_zero;
         end
         mch_pkg::OP_INS_CMP: begin
            p_raddr = pos_ff - IW'(2);
            p_we    = 1'b1;
            if (stat.shift) p_wdata = p_rdata_ff;
         end
         mch_pkg::OP_INS_PUT: p_we = 1'b1;
         mch_pkg::OP_INIT0: begin
            p_raddr = pt_a;
            s_we    = 1'b1;
            s_wdata = pt_a;
         end
         mch_pkg::OP_INIT1: begin
            p_raddr = pt_b;
            s_we    = 1'b1;
            s_waddr = SW'(depth_ff + DW'(1));
            s_wdata = pt_b;
         end
         mch_pkg::OP_PUSH_RD: p_raddr = j_ff;
         mch_pkg::OP_PUSH_WR: s_we = 1'b1;
         mch_pkg::OP_CR_EVAL: begin
            s_we    = !stat.right;
            s_waddr = SW'(depth_ff - DW'(2));
            s_wdata = t1i_ff;
         end
         mch_pkg::OP_POP_S, mch_pkg::OP_EM_P: p_raddr = s_rdata_ff;
         mch_pkg::OP_EM_S: s_raddr = (k_ff < upper_ff) ? SW'(k_ff) : SW'(k_ff + DW'(1));
         default: p_raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (p_we) pmem[p_waddr] <= p_wdata;
      p_rdata_ff <= pmem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) smem[s_waddr] <= s_wdata;
      s_rdata_ff <= smem[s_raddr];
   end

   // sign extend stored coordinates, then keep the low 16 bits
   assign ox = 32'(rx);
   assign oy = 32'(ry);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         depth_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (cmd.op)
            mch_pkg::OP_LOAD: begin
               px_ff  <= in_x32[CB-1:0];
               py_ff  <= in_y32[CB-1:0];
               fin_ff <= req_data.final_point;
               pos_ff <= IW'(cnt_ff);
               if (stat.full) ovf_ff <= 1'b1;
            end
            mch_pkg::OP_INS_RD: begin
               if (!stat.full && stat.pos_zero) cnt_ff <= cnt_ff + CW'(1);
            end
            mch_pkg::OP_INS_CMP: begin
               if (stat.shift) pos_ff <= pos_ff - IW'(1);
               else cnt_ff <= cnt_ff + CW'(1);
            end
            mch_pkg::OP_INS_PUT: cnt_ff <= cnt_ff + CW'(1);
            mch_pkg::OP_HULL: begin
               depth_ff <= '0;
               base_ff  <= '0;
               lower_ff <= 1'b0;
               j_ff     <= IW'(2);
               st_ff    <= stat.small_set ? mch_pkg::ST_FEW
                         : (ovf_ff ? mch_pkg::ST_DROP : mch_pkg::ST_OK);
            end
            mch_pkg::OP_SM_OUT: begin
               rsp_strobe_ff      <= 1'b1;
               rsp_ff.hx          <= (cnt_ff == CW'(1)) ? ox[15:0] : 16'sd0;
               rsp_ff.hy          <= (cnt_ff == CW'(1)) ? oy[15:0] : 16'sd0;
               rsp_ff.end_of_hull <= 1'b1;
               rsp_ff.status      <= st_ff;
               cnt_ff             <= '0;
               ovf_ff             <= 1'b0;
            end
            mch_pkg::OP_INIT0: t2i_ff <= pt_a;
            mch_pkg::OP_INIT1: begin
               t2x_ff <= rx;
               t2y_ff <= ry;
               t1i_ff <= pt_b;
            end
            mch_pkg::OP_INIT2: begin
               t1x_ff   <= rx;
               t1y_ff   <= ry;
               depth_ff <= depth_ff + DW'(2);
            end
            mch_pkg::OP_PUSH_WR: begin
               t3i_ff   <= t2i_ff;
               t3x_ff   <= t2x_ff;
               t3y_ff   <= t2y_ff;
               t2i_ff   <= t1i_ff;
               t2x_ff   <= t1x_ff;
               t2y_ff   <= t1y_ff;
               t1i_ff   <= j_ff;
               t1x_ff   <= rx;
               t1y_ff   <= ry;
               depth_ff <= depth_ff + DW'(1);
            end
            mch_pkg::OP_CR_MUL: begin
               prod1_ff <= PW'(d1) * PW'(d2);
               prod2_ff <= PW'(d3) * PW'(d4);
            end
            mch_pkg::OP_CR_EVAL: begin
               if (!stat.right) begin
                  t2i_ff   <= t3i_ff;
                  t2x_ff   <= t3x_ff;
                  t2y_ff   <= t3y_ff;
                  depth_ff <= depth_ff - DW'(1);
               end
            end
            mch_pkg::OP_POP_S: t3i_ff <= s_rdata_ff;
            mch_pkg::OP_POP_P: begin
               t3x_ff <= rx;
               t3y_ff <= ry;
            end
            mch_pkg::OP_NEXT: begin
               if (!stat.last_push) begin
                  j_ff <= lower_ff ? (j_ff - IW'(1)) : (j_ff + IW'(1));
               end else if (!lower_ff) begin
                  lower_ff <= 1'b1;
                  upper_ff <= depth_ff;
                  base_ff  <= depth_ff;
                  j_ff     <= IW'(cnt_ff - CW'(3));
               end
            end
            mch_pkg::OP_EM_INIT: begin
               k_ff     <= '0;
               total_ff <= upper_ff + ((span > DW'(2)) ? (span - DW'(2)) : '0);
            end
            mch_pkg::OP_EM_OUT: begin
               rsp_strobe_ff      <= 1'b1;
               rsp_ff.hx          <= ox[15:0];
               rsp_ff.hy          <= oy[15:0];
               rsp_ff.end_of_hull <= stat.em_last;
               rsp_ff.status      <= st_ff;
               k_ff               <= k_ff + DW'(1);
               if (stat.em_last) begin
                  cnt_ff <= '0;
                  ovf_ff <= 1'b0;
               end
            end
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS))
      else $error("point count beyond capacity");
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(2 * MAX_POINTS))
      else $error("chain stack overrun");
   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.end_of_hull) |-> (cnt_ff == '0 && !ovf_ff))
      else $error("set not cleared after last vertex");
`endif

endmodule

[rtl/monotone_chain_convex_hull_core.sv]
// top level of the monotone chain convex hull core
// load: on an empty or full store the point is written or dropped at once, else each larger
// stored point is shifted up in turn; the next item is taken once busy falls
// final item: each chain is seeded with two points, then each point is pushed and the turn
// retested after every pop; results: one vertex per stack read, point read and strobe
// reset clears point count, overflow flag, stack depth and response strobe; the stores need no clearing
module monotone_chain_convex_hull_core #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mch_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mch_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   mch_pkg::cmd_type  cmd;
   mch_pkg::stat_type stat;

   // controller: walks insertion, upper chain, lower chain, then emission, or one result for a small set
   mch_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // datapath: sorted point memory, index stack, cross product with registered products
   mch_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[bench/monotone_chain_convex_hull_core_test.sv]
`timescale 1ns / 100ps
// self-checking bench for the monotone chain convex hull core
module monotone_chain_convex_hull_core_test;

   localparam int CAP = 64;

   // keeps the sorted point set, builds both chains on the final item and
   // holds the vertices still owed by the core
   class hull_scoreboard;
      logic signed [15:0] pxs [CAP];
      logic signed [15:0] pys [CAP];
      int                 count;
      bit                 dropped;
      mch_pkg::rsp_type   owed [$];
      int                 errors;

      function new();
         count = 0;
         dropped = 0;
         errors = 0;
      endfunction

      // strict right turn of store entries a, b, c
      function bit turns_right(int a, int b, int c);
         longint cr;
         cr = (longint'(pxs[b]) - pxs[a]) * (longint'(pys[c]) - pys[a])
            - (longint'(pxs[c]) - pxs[a]) * (longint'(pys[b]) - pys[a]);
         return cr < 0;
      endfunction

      function void note_item(mch_pkg::req_type it);
         int      i;
         int      chain [$];
         int      lo_base;
         int      upper;
         int      total;
         logic [1:0] st;
         mch_pkg::rsp_type r;
         // sorted insert, equal points keep arrival order
         if (count >= CAP) dropped = 1;
         else begin
            i = count;
            while (i > 0 && (pxs[i-1] > it.px || (pxs[i-1] == it.px && pys[i-1] > it.py)))
            begin
               pxs[i] = pxs[i-1];
               pys[i] = pys[i-1];
               i--;
            end
            pxs[i] = it.px;
            pys[i] = it.py;
            count++;
         end
         if (!it.final_point) return;
         st = (count < 2) ? mch_pkg::ST_FEW : (dropped ? mch_pkg::ST_DROP : mch_pkg::ST_OK);
         if (count < 2) begin
            r.hx = (count == 1) ? pxs[0] : 16'sd0;
            r.hy = (count == 1) ? pys[0] : 16'sd0;
            r.end_of_hull = 1;
            r.status = st;
            owed = {owed, r};
         end else begin
            chain = {0, 1};
            for (i = 2; i < count; i++) begin
               chain = {chain, i};
               while (chain.size() > 2 && !turns_right(chain[$-2], chain[$-1], chain[$]))
                  chain.delete(chain.size() - 2);
            end
            upper = chain.size();
            lo_base = upper;
            chain = {chain, count - 1};
            chain = {chain, count - 2};
            for (i = count - 2; i > 0; i--) begin
               chain = {chain, i - 1};
               while (chain.size() - lo_base > 2
                      && !turns_right(chain[$-2], chain[$-1], chain[$]))
                  chain.delete(chain.size() - 2);
            end
            // lower chain without its shared end points
            chain.delete(chain.size() - 1);
            chain.delete(lo_base);
            total = chain.size();
            if (total > CAP) total = CAP;
            for (i = 0; i < total; i++) begin
               r.hx = pxs[chain[i]];
               r.hy = pys[chain[i]];
               r.end_of_hull = (i == total - 1);
               r.status = st;
               owed = {owed, r};
            end
         end
         count = 0;
         dropped = 0;
      endfunction

      function void check_vertex(mch_pkg::rsp_type got);
         mch_pkg::rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected vertex %p", got);
            return;
         end
         want = owed.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("vertex mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             start = 0;
   logic             busy;
   mch_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   mch_pkg::rsp_type rsp_data;

   hull_scoreboard hull_sb = new();
   int             burst_left = 0;
   int             sent = 0;

   monotone_chain_convex_hull_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // every strobed vertex is checked at the edge that accepts it
   always @(posedge clock) begin
      if (!reset && rsp_strobe) hull_sb.check_vertex(rsp_data);
   end

   // hand one item to the core, with burst-shaped gaps in front of it;
   // returns at the edge that accepts the item
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic fin);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
         if (gap != 0) begin
            start <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_data.px = x;
      req_data.py = y;
      req_data.final_point = fin;
      start <= 1;
      while (busy) @(negedge clock);
      @(posedge clock);
      hull_sb.note_item(req_data);
      sent++;
   endtask

   function automatic logic signed [15:0] pick_coord(int span);
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($signed($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   // one point set of n points, final mark on the last
   task automatic send_set(int n, int span);
      int i;
      for (i = 0; i < n; i++)
         send_point(pick_coord(span), pick_coord(span), i == n - 1);
   endtask

   initial begin
      int i;
      int n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // repeated extreme point, single point, equal pair
      send_point(16'sh7fff, 16'sh8000, 0);
      send_point(16'sh7fff, 16'sh8000, 0);
      send_point(0, 0, 1);
      send_point(16'sh8000, 16'sh7fff, 1);
      send_point(5, 5, 0);
      send_point(5, 5, 1);
      // collinear run
      for (i = 0; i < 4; i++) send_point(16'(3 * i), 16'(-2 * i), i == 3);
      // square with a center point
      send_point(16'sh8000, 16'sh8000, 0);
      send_point(16'sh7fff, 16'sh7fff, 0);
      send_point(16'sh8000, 16'sh7fff, 0);
      send_point(0, 0, 0);
      send_point(16'sh7fff, 16'sh8000, 1);
      // capacity overflow
      send_set(CAP + 3, 1000);

      // random sets, mostly small, one large now and then
      while (sent < 330) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66) : $urandom_range(1, 8);
         send_set(n, $urandom_range(0, 1) ? 4 : 30000);
      end
      @(negedge clock);
      start <= 0;

      while (hull_sb.owed.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (hull_sb.errors == 0 && hull_sb.owed.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule

[files.f]
rtl/mch_pkg.sv
rtl/mch_ctrl.sv
rtl/mch_dp.sv
rtl/monotone_chain_convex_hull_core.sv
bench/monotone_chain_convex_hull_core_test.sv
